FILE: hw/rtl/fgns_pkg.sv
// Shared types, grid geometry and the search offset table for the feature grid search.
// Used by every module of the block except fgns_ram; depends on nothing else.
package fgns_pkg;

  localparam int GRID_WIDTH    = 640;
  localparam int GRID_HEIGHT   = 480;
  localparam int SEARCH_RADIUS = 8;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int OFF_MAX    = (2 * SEARCH_RADIUS + 1) * (2 * SEARCH_RADIUS + 1);
  localparam int COORD_W    = 14;
  localparam int OFF_W      = 8;

  localparam int POS_X_W   = 10;
  localparam int POS_Y_W   = 9;
  localparam int FEATURE_W = 10;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  function automatic int count_offsets();
    int n;
    n = 0;
    for (int a = -SEARCH_RADIUS; a <= SEARCH_RADIUS; a++) begin
      for (int b = -SEARCH_RADIUS; b <= SEARCH_RADIUS; b++) begin
        if (a * a + b * b < SEARCH_RADIUS * SEARCH_RADIUS) begin
          n++;
        end
      end
    end
    return n;
  endfunction

  localparam int OFF_COUNT = count_offsets();
  localparam int OFF_IDX_W = $clog2(OFF_COUNT + 1);

  typedef struct packed {
    logic                 action;
    logic [POS_X_W-1:0]   pos_x;
    logic [POS_Y_W-1:0]   pos_y;
    logic                 cell_occupied;
    logic [FEATURE_W-1:0] cell_feature;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [FEATURE_W-1:0] nearest_feature;
  } out_item_t;

  typedef struct packed {
    logic                 occupied;
    logic [FEATURE_W-1:0] feature;
  } grid_word_t;

  localparam int GRID_WORD_W = $bits(grid_word_t);

  typedef struct packed {
    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
  } offset_t;

  typedef offset_t [OFF_COUNT-1:0] offset_table_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic write;
    logic issue;
    logic capture;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic issue_done;
    logic pipe_busy;
    logic hit;
  } status_t;

  // Offsets inside the radius, generated dx-major, then exchange-sorted by squared distance.
  function automatic offset_table_t build_offset_table();
    offset_table_t tab;
    int            sq_dist [OFF_MAX];
    int            n;
    int            r;
    int            lim;
    int            t_d;
    offset_t       t_off;
    tab = '0;
    n   = 0;
    lim = SEARCH_RADIUS * SEARCH_RADIUS;
    for (int a = -SEARCH_RADIUS; a <= SEARCH_RADIUS; a++) begin
      for (int b = -SEARCH_RADIUS; b <= SEARCH_RADIUS; b++) begin
        r = a * a + b * b;
        if (r < lim) begin
          sq_dist[n] = r;
          tab[n].dx  = OFF_W'(a);
          tab[n].dy  = OFF_W'(b);
          n++;
        end
      end
    end
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (sq_dist[i] > sq_dist[j]) begin
          t_d        = sq_dist[i];
          sq_dist[i] = sq_dist[j];
          sq_dist[j] = t_d;
          t_off      = tab[i];
          tab[i]     = tab[j];
          tab[j]     = t_off;
        end
      end
    end
    return tab;
  endfunction

  localparam offset_table_t OFF_TABLE = build_offset_table();

endpackage

FILE: hw/rtl/fgns_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
module fgns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fgns_datapath.sv
// Datapath: item latch, grid clear counter, offset probe pipeline, grid RAM and result registers.
// Depends on fgns_pkg and fgns_ram.
module fgns_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  fgns_pkg::cmd_t     cmd,
  input  fgns_pkg::in_item_t in_item,
  output fgns_pkg::status_t  sts,
  output fgns_pkg::out_item_t out_item
);

  fgns_pkg::in_item_t                     item_r;
  logic [fgns_pkg::ADDR_W-1:0]            clr_addr_r;
  logic [fgns_pkg::OFF_IDX_W-1:0]         k_r;
  fgns_pkg::offset_t                      off_r;
  logic                                   v_off_r;
  logic [fgns_pkg::ADDR_W-1:0]            cx_r;
  logic [fgns_pkg::ADDR_W-1:0]            cy_r;
  logic                                   v_xy_r;
  logic [fgns_pkg::ADDR_W-1:0]            addr_r;
  logic                                   v_addr_r;
  logic                                   v_data_r;
  logic                                   res_found_r;
  logic [fgns_pkg::FEATURE_W-1:0]         res_feat_r;
  fgns_pkg::out_item_t                    out_item_r;

  logic signed [fgns_pkg::COORD_W-1:0]    xs;
  logic signed [fgns_pkg::COORD_W-1:0]    ys;
  logic                                   inb;
  logic                                   wr_in_range;
  logic [fgns_pkg::ADDR_W-1:0]            wr_addr;
  logic                                   ram_we;
  logic [fgns_pkg::ADDR_W-1:0]            ram_waddr;
  fgns_pkg::grid_word_t                   ram_wdata;
  fgns_pkg::grid_word_t                   ram_rdata;
  logic                                   hit;

  always_comb begin
    xs = $signed(fgns_pkg::COORD_W'(item_r.pos_x))
       + {{(fgns_pkg::COORD_W - fgns_pkg::OFF_W){off_r.dx[fgns_pkg::OFF_W-1]}}, off_r.dx};
    ys = $signed(fgns_pkg::COORD_W'(item_r.pos_y))
       + {{(fgns_pkg::COORD_W - fgns_pkg::OFF_W){off_r.dy[fgns_pkg::OFF_W-1]}}, off_r.dy};
    inb = (xs >= 0) && (xs < $signed(fgns_pkg::COORD_W'(fgns_pkg::GRID_WIDTH)))
       && (ys >= 0) && (ys < $signed(fgns_pkg::COORD_W'(fgns_pkg::GRID_HEIGHT)));
  end

  assign wr_in_range = (32'(item_r.pos_x) < fgns_pkg::GRID_WIDTH)
                    && (32'(item_r.pos_y) < fgns_pkg::GRID_HEIGHT);
  assign wr_addr = fgns_pkg::ADDR_W'(item_r.pos_y) * fgns_pkg::ADDR_W'(fgns_pkg::GRID_WIDTH)
                 + fgns_pkg::ADDR_W'(item_r.pos_x);

  always_comb begin
    ram_we    = cmd.clear || (cmd.write && wr_in_range);
    ram_waddr = cmd.clear ? clr_addr_r : wr_addr;
    ram_wdata = '0;
    if (!cmd.clear && item_r.cell_occupied) begin
      ram_wdata.occupied = 1'b1;
      ram_wdata.feature  = item_r.cell_feature;
    end
  end

  fgns_ram #(
    .WIDTH(fgns_pkg::GRID_WORD_W),
    .DEPTH(fgns_pkg::CELL_COUNT)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (v_addr_r),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  assign hit = v_data_r && ram_rdata.occupied;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      k_r         <= '0;
      v_off_r     <= 1'b0;
      v_xy_r      <= 1'b0;
      v_addr_r    <= 1'b0;
      v_data_r    <= 1'b0;
      res_found_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.latch) begin
        k_r         <= '0;
        v_off_r     <= 1'b0;
        v_xy_r      <= 1'b0;
        v_addr_r    <= 1'b0;
        v_data_r    <= 1'b0;
        res_found_r <= 1'b0;
      end else begin
        v_off_r  <= cmd.issue;
        v_xy_r   <= v_off_r && inb;
        v_addr_r <= v_xy_r;
        v_data_r <= v_addr_r;
        if (cmd.issue) begin
          k_r <= k_r + 1'b1;
        end
        if (cmd.capture && hit) begin
          res_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r     <= in_item;
      res_feat_r <= '0;
    end else if (cmd.capture && hit) begin
      res_feat_r <= ram_rdata.feature;
    end
    if (cmd.issue) begin
      off_r <= fgns_pkg::OFF_TABLE[k_r];
    end
    cx_r   <= fgns_pkg::ADDR_W'($unsigned(xs));
    cy_r   <= fgns_pkg::ADDR_W'($unsigned(ys));
    addr_r <= cy_r * fgns_pkg::ADDR_W'(fgns_pkg::GRID_WIDTH) + cx_r;
    if (cmd.load_out) begin
      out_item_r.found           <= res_found_r;
      out_item_r.nearest_feature <= res_feat_r;
    end
  end

  assign sts.clear_last = (clr_addr_r == fgns_pkg::ADDR_W'(fgns_pkg::CELL_COUNT - 1));
  assign sts.issue_done = (32'(k_r) >= fgns_pkg::OFF_COUNT);
  assign sts.pipe_busy  = v_off_r || v_xy_r || v_addr_r || v_data_r;
  assign sts.hit        = hit;
  assign out_item       = out_item_r;

endmodule

FILE: hw/rtl/fgns_ctrl.sv
// Controller: grid clear after reset, item dispatch, probe sequencing and output handshake.
// Depends on fgns_pkg.
module fgns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fgns_pkg::status_t sts,
  output fgns_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_PROBE,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = (in_action == fgns_pkg::ACT_QUERY) ? ST_PROBE : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_PROBE: begin
        cmd.issue   = !sts.issue_done && !sts.hit;
        cmd.capture = 1'b1;
        if (sts.hit || (sts.issue_done && !sts.pipe_busy)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/feature_grid_nearest_search.sv
// Top level of the feature grid nearest search block.
// Depends on fgns_pkg, fgns_ctrl and fgns_datapath.
//
// After reset the block clears the whole grid RAM, one cell per cycle; in_stall stays
// high during that pass. Afterwards one item is handled at a time. A write item is
// latched on acceptance, written to the grid RAM in the write state and loaded into
// the output register in the finish state. A query walks the sorted offset table one
// entry per cycle through a four-stage probe pipeline that ends in the grid RAM read
// port; it stops at the first hit or, when nothing is found, once every offset has been
// issued and the pipeline has drained. A finished result sits in an output register, so
// the next item is accepted while the previous result is still waiting to be taken.
module feature_grid_nearest_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fgns_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fgns_pkg::out_item_t out_item
);

  fgns_pkg::cmd_t    cmd;
  fgns_pkg::status_t sts;

  fgns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_item.action),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fgns_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_item),
    .sts     (sts),
    .out_item(out_item)
  );

endmodule

FILE: hw/rtl/fgns_checker.sv
// Port-level checks for the feature grid nearest search block, bound to its top level.
// Depends on fgns_pkg.
module fgns_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input fgns_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input fgns_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed or vanished.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("Stalled input item changed or was withdrawn.");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |-> out_item.nearest_feature == '0)
    else $error("Result without a hit carries a nonzero feature.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Second item accepted while one is in work.");

endmodule

bind feature_grid_nearest_search fgns_checker u_fgns_checker (.*);
